### src/plr_pkg.sv
package plr_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_VALUE_BITS = 32;

	localparam int PC_BITS = 7;
	localparam int EM_BITS = 16;
	localparam int IDX_BITS = 6;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_COUNT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_MARGIN = 1'd1;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_EMPTY,
		STATUS_ZERO_SEG,
		STATUS_LOAD_DONE
	} status_t;

endpackage

### src/plr_if.sv
interface plr_in_if #(parameter int VALUE_BITS = plr_pkg::DEF_VALUE_BITS);
	import plr_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [IDX_BITS-1:0]          point_index;
	logic signed [VALUE_BITS-1:0] point_arc_length;
	logic signed [VALUE_BITS-1:0] point_deviation;
	logic signed [VALUE_BITS-1:0] query_arc_length;

	modport source (
		output valid, cmd, point_index, point_arc_length, point_deviation, query_arc_length,
		input  ready
	);

	modport sink (
		input  valid, cmd, point_index, point_arc_length, point_deviation, query_arc_length,
		output ready
	);

endinterface

interface plr_out_if #(parameter int VALUE_BITS = plr_pkg::DEF_VALUE_BITS);
	import plr_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] deviation_out;
	status_t                      status;

	modport source (
		output valid, deviation_out, status,
		input  ready
	);

	modport sink (
		input  valid, deviation_out, status,
		output ready
	);

endinterface

### src/polyline_linear_interpolation_core.sv
// Channel  Direction  Transfer moves
// item     in         cmd, point_index, point_arc_length, point_deviation, query_arc_length
// result   out        deviation_out, status
// cfg      in         cfg_we, cfg_index, cfg_data (written on any edge with cfg_we high)
//
// A load or an empty-table query goes to ST_DONE, where every result enters the output
// register as the input is freed; a query clamped to a table end first passes ST_FIRST,
// ST_LAST, ST_CHECK. An interior query adds ST_SCAN, one entry per cycle up to the point
// count capped at MAX_POINTS, ST_SEG0..2, then the one-bit-per-cycle divider if dl != 0.
// Reset clears the control state and config registers; the point memories are not cleared.
// A waiting result sits in the output register while the next item is taken.
module polyline_linear_interpolation_core #(
	parameter int MAX_POINTS = plr_pkg::DEF_MAX_POINTS,
	parameter int VALUE_BITS = plr_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [plr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [plr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	plr_in_if.sink                           item,
	plr_out_if.source                        result
);
	import plr_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = ($clog2(MAX_POINTS + 1) > PC_BITS) ? $clog2(MAX_POINTS + 1) : PC_BITS;
	localparam int V1 = VALUE_BITS + 1;
	localparam int SW = VALUE_BITS + 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_CHECK,
		ST_SCAN,
		ST_SEG0,
		ST_SEG1,
		ST_SEG2,
		ST_MULDIV,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic                         out_valid_q;
	logic [PC_BITS-1:0]           point_count_q;
	logic [EM_BITS-1:0]           edge_margin_q;

	logic signed [VALUE_BITS-1:0] q_q;
	logic [AW-1:0]                last_q;
	logic [AW-1:0]                scan_idx_q;
	logic [AW-1:0]                seg_q;
	logic signed [VALUE_BITS-1:0] a0_q;
	logic signed [VALUE_BITS-1:0] d0_q;
	logic signed [VALUE_BITS-1:0] as_q;
	logic signed [VALUE_BITS-1:0] ds_q;
	logic                         neg_q;
	logic signed [VALUE_BITS-1:0] res_q;
	status_t                      status_q;
	logic signed [VALUE_BITS-1:0] out_dev_q;
	status_t                      out_status_q;

	logic                         accept;
	logic                         load_we;
	logic [CW-1:0]                n_pts;
	logic [AW-1:0]                raddr;
	logic [VALUE_BITS-1:0]        rd_arc;
	logic [VALUE_BITS-1:0]        rd_dev;
	logic signed [V1-1:0]         q_x;
	logic signed [V1-1:0]         margin_x;
	logic signed [V1-1:0]         lo_lim;
	logic signed [V1-1:0]         hi_lim;
	logic                         scan_hit;
	logic                         scan_end;
	logic signed [V1-1:0]         dl;
	logic signed [V1-1:0]         dd;
	logic signed [V1-1:0]         dq;
	logic [V1-1:0]                mag_dl;
	logic [V1-1:0]                mag_dd;
	logic [V1-1:0]                mag_dq;
	logic                         md_start;
	logic                         md_done;
	logic [VALUE_BITS+1:0]        md_quot;
	logic signed [SW-1:0]         quot_x;
	logic signed [SW-1:0]         sum;
	logic signed [VALUE_BITS-1:0] sum_sat;
	logic                         out_load;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign load_we = accept && (item.cmd == CMD_LOAD)
		&& (32'(item.point_index) < MAX_POINTS);
	assign n_pts = (CW'(point_count_q) > CW'(MAX_POINTS)) ? CW'(MAX_POINTS)
		: CW'(point_count_q);

	always_comb begin
		case (state_q)
			ST_LAST: raddr = last_q;
			ST_SCAN: raddr = scan_idx_q + AW'(1);
			ST_SEG0: raddr = seg_q;
			ST_SEG1: raddr = seg_q + AW'(1);
			default: raddr = '0;
		endcase
	end

	plr_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_POINTS)) u_arc_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(item.point_index)),
		.wdata (item.point_arc_length),
		.raddr (raddr),
		.rdata (rd_arc)
	);

	plr_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_POINTS)) u_dev_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(item.point_index)),
		.wdata (item.point_deviation),
		.raddr (raddr),
		.rdata (rd_dev)
	);

	assign q_x = V1'(q_q);
	assign margin_x = V1'($signed({1'b0, edge_margin_q}));
	assign lo_lim = V1'(a0_q) + margin_x;
	assign hi_lim = V1'($signed(rd_arc)) - margin_x;

	assign scan_hit = $signed(rd_arc) > q_q;
	assign scan_end = scan_hit || (scan_idx_q == last_q);

	assign dl = V1'($signed(rd_arc)) - V1'(as_q);
	assign dd = V1'($signed(rd_dev)) - V1'(ds_q);
	assign dq = q_x - V1'(as_q);
	assign mag_dl = $unsigned(dl[V1-1] ? -dl : dl);
	assign mag_dd = $unsigned(dd[V1-1] ? -dd : dd);
	assign mag_dq = $unsigned(dq[V1-1] ? -dq : dq);
	assign md_start = (state_q == ST_SEG2) && (dl != '0);

	plr_muldiv #(.VALUE_BITS(VALUE_BITS)) u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (md_start),
		.mag_dd   (mag_dd),
		.mag_dq   (mag_dq),
		.mag_dl   (mag_dl),
		.done     (md_done),
		.quotient (md_quot)
	);

	assign quot_x = $signed({1'b0, md_quot});
	assign sum = SW'(ds_q) + (neg_q ? -quot_x : quot_x);

	always_comb begin
		if ((&sum[SW-1:VALUE_BITS-1]) || !(|sum[SW-1:VALUE_BITS-1])) begin
			sum_sat = sum[VALUE_BITS-1:0];
		end else if (sum[SW-1]) begin
			sum_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign result.valid = out_valid_q;
	assign result.deviation_out = out_dev_q;
	assign result.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			edge_margin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POINT_COUNT: point_count_q <= cfg_data[PC_BITS-1:0];
				CFG_EDGE_MARGIN: edge_margin_q <= cfg_data[EM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_QUERY && n_pts != '0) begin
							state_q <= ST_FIRST;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FIRST: state_q <= ST_LAST;
				ST_LAST:  state_q <= ST_CHECK;
				ST_CHECK: begin
					if (q_x <= lo_lim || hi_lim <= q_x) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_SEG0;
					end
				end
				ST_SEG0: state_q <= ST_SEG1;
				ST_SEG1: state_q <= ST_SEG2;
				ST_SEG2: begin
					if (dl == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MULDIV;
					end
				end
				ST_MULDIV: begin
					if (md_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dev_q <= res_q;
			out_status_q <= status_q;
		end
		case (state_q)
			ST_IDLE: begin
				q_q <= item.query_arc_length;
				last_q <= AW'(n_pts - CW'(1));
				res_q <= '0;
				status_q <= (item.cmd == CMD_LOAD) ? STATUS_LOAD_DONE : STATUS_EMPTY;
			end
			ST_LAST: begin
				a0_q <= $signed(rd_arc);
				d0_q <= $signed(rd_dev);
			end
			ST_CHECK: begin
				status_q <= STATUS_OK;
				scan_idx_q <= '0;
				if (q_x <= lo_lim) begin
					res_q <= d0_q;
				end else begin
					res_q <= $signed(rd_dev);
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					seg_q <= (scan_idx_q == '0) ? '0 : scan_idx_q - AW'(1);
				end else begin
					scan_idx_q <= scan_idx_q + AW'(1);
				end
			end
			ST_SEG1: begin
				as_q <= $signed(rd_arc);
				ds_q <= $signed(rd_dev);
			end
			ST_SEG2: begin
				neg_q <= dd[V1-1] ^ dq[V1-1] ^ dl[V1-1];
				if (dl == '0) begin
					res_q <= ds_q;
					status_q <= STATUS_ZERO_SEG;
				end
			end
			ST_MULDIV: begin
				if (md_done) begin
					res_q <= sum_sat;
				end
			end
			default: begin
			end
		endcase
	end

	a_done_in_muldiv: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == ST_MULDIV)
		else $error("divider finished outside the interpolation step");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_idx_q <= last_q)
		else $error("scan ran past the last table point");

	a_search_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEG0 |-> last_q != '0)
		else $error("segment search with fewer than two points");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished result did not reach the output register");

endmodule

### src/plr_ram.sv
module plr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/plr_muldiv.sv
module plr_muldiv #(
	parameter int VALUE_BITS = plr_pkg::DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS:0]   mag_dd,
	input  logic [VALUE_BITS:0]   mag_dq,
	input  logic [VALUE_BITS:0]   mag_dl,
	output logic                  done,
	output logic [VALUE_BITS+1:0] quotient
);
	import plr_pkg::*;

	localparam int MW = VALUE_BITS + 1;
	localparam int H = (MW + 1) / 2;
	localparam int AW = 4 * H;
	localparam int DW = 2 * MW - 1;
	localparam int QW = VALUE_BITS + 2;
	localparam int DCW = $clog2(DW + 1);

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	md_state_t          state_q;
	logic [2:0]         mul_cnt_q;
	logic [DCW-1:0]     div_cnt_q;
	logic               done_q;
	logic [2*H-1:0]     a_q;
	logic [2*H-1:0]     b_q;
	logic [MW-1:0]      den_q;
	logic [MW-1:0]      rem_q;
	logic [2*H-1:0]     pp_q;
	logic [1:0]         sh_q;
	logic [AW-1:0]      acc_q;
	logic [H-1:0]       a_part;
	logic [H-1:0]       b_part;
	logic [AW-1:0]      pp_shifted;
	logic [MW:0]        trial;
	logic               trial_ge;
	logic [MW-1:0]      rem_next;
	logic [QW-1:0]      qmax;

	assign a_part = mul_cnt_q[1] ? a_q[2*H-1:H] : a_q[H-1:0];
	assign b_part = mul_cnt_q[0] ? b_q[2*H-1:H] : b_q[H-1:0];

	always_comb begin
		case (sh_q)
			2'd0:    pp_shifted = AW'(pp_q);
			2'd1:    pp_shifted = AW'(pp_q) << H;
			default: pp_shifted = AW'(pp_q) << (2 * H);
		endcase
	end

	assign trial = {rem_q, acc_q[DW-1]};
	assign trial_ge = trial >= {1'b0, den_q};
	assign rem_next = trial_ge ? MW'(trial - {1'b0, den_q}) : MW'(trial);

	assign qmax = {1'b1, {(QW-1){1'b0}}};
	assign quotient = (acc_q[DW-1:0] >= DW'(qmax)) ? qmax : QW'(acc_q[DW-1:0]);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			mul_cnt_q <= '0;
			div_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (start) begin
						mul_cnt_q <= '0;
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					mul_cnt_q <= mul_cnt_q + 3'd1;
					if (mul_cnt_q == 3'd4) begin
						div_cnt_q <= '0;
						state_q <= MD_DIV;
					end
				end
				MD_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(DW - 1)) begin
						done_q <= 1'b1;
						state_q <= MD_IDLE;
					end
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					a_q <= (2*H)'(mag_dd);
					b_q <= (2*H)'(mag_dq);
					den_q <= mag_dl;
					rem_q <= '0;
					acc_q <= '0;
				end
			end
			MD_MUL: begin
				if (mul_cnt_q != 3'd4) begin
					pp_q <= a_part * b_part;
					sh_q <= {1'b0, mul_cnt_q[1]} + {1'b0, mul_cnt_q[0]};
				end
				if (mul_cnt_q != 3'd0) begin
					acc_q <= acc_q + pp_shifted;
				end
			end
			MD_DIV: begin
				rem_q <= rem_next;
				acc_q[DW-1:0] <= {acc_q[DW-2:0], trial_ge};
			end
			default: begin
			end
		endcase
	end

endmodule
